FILE: sv/hbs_pkg.sv
package hbs_pkg;

  // Defaults for the top-level size parameters.
  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF    = 4096;

  // Configuration port.
  localparam int unsigned CFG_AW     = 1;
  localparam int unsigned CFG_DW     = 13;
  localparam int unsigned COLS_RAW_W = 11;
  localparam int unsigned ROWS_RAW_W = 13;
  localparam int unsigned COLS_RESET = 1024;
  localparam int unsigned ROWS_RESET = 1024;

  localparam logic [CFG_AW-1:0] REG_MAP_COLUMNS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_MAP_ROWS    = 1'b1;

  // Input opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Output field widths.
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned OROW_W   = 12;
  localparam int unsigned OCOL_W   = 10;

  // Mean arithmetic: height*64 = S*38400/(255*n) = S*2560/(17*n).
  localparam int unsigned SUM_W     = 12;   // up to nine bytes
  localparam int unsigned CNT_W     = 4;    // up to nine cells
  localparam int unsigned DIV_W     = 8;    // 17*n, up to 153
  localparam int unsigned NUM_W     = 23;   // S*2560
  localparam int unsigned RECIP_SH  = 23;
  localparam int unsigned RECIP_W   = 19;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;
  localparam int unsigned REM_W     = NUM_W + 1;
  localparam int unsigned DIV_BASE  = 17;

  localparam int unsigned RECIP_N1 = (1 << RECIP_SH) / (DIV_BASE * 1);
  localparam int unsigned RECIP_N2 = (1 << RECIP_SH) / (DIV_BASE * 2);
  localparam int unsigned RECIP_N3 = (1 << RECIP_SH) / (DIV_BASE * 3);
  localparam int unsigned RECIP_N4 = (1 << RECIP_SH) / (DIV_BASE * 4);
  localparam int unsigned RECIP_N6 = (1 << RECIP_SH) / (DIV_BASE * 6);
  localparam int unsigned RECIP_N9 = (1 << RECIP_SH) / (DIV_BASE * 9);

  typedef struct packed {
    logic       opcode;
    logic [7:0] sample_byte;
  } in_word_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] smoothed_height;
    logic [OROW_W-1:0]   out_row;
    logic [OCOL_W-1:0]   out_col;
    logic                frame_last;
  } out_word_t;

  // Window sum and cell count of one position, on its way to the divider.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } mean_req_t;

  // Reciprocal of 17*n, scaled by 2^RECIP_SH and rounded down.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = RECIP_W'(RECIP_N1);
      4'd2:    r = RECIP_W'(RECIP_N2);
      4'd3:    r = RECIP_W'(RECIP_N3);
      4'd4:    r = RECIP_W'(RECIP_N4);
      4'd6:    r = RECIP_W'(RECIP_N6);
      4'd9:    r = RECIP_W'(RECIP_N9);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/hbs_mean_div.sv
module hbs_mean_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 req_valid_i,
  input  hbs_pkg::mean_req_t   req_i,
  output logic                 res_valid_o,
  output hbs_pkg::out_word_t   res_o
);

  hbs_pkg::mean_req_t a_q;
  logic               a_valid_q;

  logic [hbs_pkg::NUM_W-1:0]    a_num;
  logic [hbs_pkg::PROD_W-1:0]   a_prod;
  logic [hbs_pkg::DIV_W-1:0]    a_div;

  logic                         b_valid_q;
  logic [hbs_pkg::NUM_W-1:0]    b_num_q;
  logic [hbs_pkg::HEIGHT_W-1:0] b_q0_q;
  logic [hbs_pkg::DIV_W-1:0]    b_div_q;
  logic [hbs_pkg::OROW_W-1:0]   b_row_q;
  logic [hbs_pkg::OCOL_W-1:0]   b_col_q;
  logic                         b_last_q;

  logic [hbs_pkg::REM_W-1:0]    b_rem;
  logic [hbs_pkg::HEIGHT_W-1:0] b_quot;

  logic                         res_valid_q;
  hbs_pkg::out_word_t           res_q;

  // First step: scale the sum and multiply by the reciprocal of the divisor.
  // The truncated reciprocal leaves the quotient at most one too small.
  always_comb begin
    a_num  = (hbs_pkg::NUM_W'(a_q.sum) << 11) + (hbs_pkg::NUM_W'(a_q.sum) << 9);
    a_prod = hbs_pkg::PROD_W'(a_num) * hbs_pkg::PROD_W'(hbs_pkg::recip(a_q.cnt));
    a_div  = (hbs_pkg::DIV_W'(a_q.cnt) << 4) + hbs_pkg::DIV_W'(a_q.cnt);
  end

  // Second step: one remainder check fixes the estimate.
  always_comb begin
    b_rem  = hbs_pkg::REM_W'(b_num_q)
           - hbs_pkg::REM_W'(hbs_pkg::REM_W'(b_q0_q) * hbs_pkg::REM_W'(b_div_q));
    b_quot = b_q0_q + hbs_pkg::HEIGHT_W'(b_rem >= hbs_pkg::REM_W'(b_div_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q   <= req_valid_i;
      b_valid_q   <= a_valid_q;
      res_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (req_valid_i) begin
        a_q <= req_i;
      end
      if (a_valid_q) begin
        b_num_q  <= a_num;
        b_q0_q   <= hbs_pkg::HEIGHT_W'(a_prod >> hbs_pkg::RECIP_SH);
        b_div_q  <= a_div;
        b_row_q  <= a_q.row;
        b_col_q  <= a_q.col;
        b_last_q <= a_q.last;
      end
      if (b_valid_q) begin
        res_q.smoothed_height <= b_quot;
        res_q.out_row         <= b_row_q;
        res_q.out_col         <= b_col_q;
        res_q.frame_last      <= b_last_q;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: sv/heightmap_box_smooth_3x3_core.sv
// 3x3 box smoothing of a height map streamed in raster order.
// Input words carry an opcode and a height byte; a flush word counts as a zero
// sample. Each word may complete one map position, whose smoothed height
// (mean of the in-map neighbours times 38400/255, truncated), row, column and a
// frame-last flag leave on the output channel. A position completes one row
// plus one pixel after its own sample, so after the last sample of a frame the
// host sends map_columns+1 flush words. After the frame-last word the counters
// restart and the next word begins a new frame.
// The block takes one word per clock unless the output stalls. Each result is
// registered in the first stage, in each divider step and in the output. The
// rate is set by the single line memory, which is read and written once per
// word, and the pipeline behind it (window, multiply, correct, output register).
// When the receiver stalls a waiting result, the whole pipeline holds and the
// input is stalled in the same cycle. Writing either map size register
// restarts the frame; do so only while the block is drained.
// Reset sets both sizes to 1024 and empties the pipeline; the line memory
// needs no clearing pass.
module heightmap_box_smooth_3x3_core #(
  parameter int unsigned MAX_COLUMNS = hbs_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = hbs_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hbs_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [hbs_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hbs_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hbs_pkg::out_word_t         out_word_o
);

  localparam int unsigned COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned COL_CW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ROW_CW = $clog2(MAX_ROWS + 3);

  logic [hbs_pkg::COLS_RAW_W-1:0] cols_raw_q;
  logic [hbs_pkg::ROWS_RAW_W-1:0] rows_raw_q;
  logic [COL_CW-1:0]              w_eff;
  logic [ROW_CW-1:0]              h_eff;

  logic [COL_AW-1:0] col_q, col_d;
  logic [ROW_CW-1:0] row_q, row_d;

  logic              adv, accept;
  logic [COL_CW-1:0] col_ext, col_inc, ocol;
  logic [ROW_CW-1:0] orow;
  logic              is_a, is_b, has, last;
  logic [2:0]        rmask, cmask;
  logic [1:0]        nrows, ncols;
  logic [hbs_pkg::CNT_W-1:0] cnt;

  // First stage: the word whose line memory read is in flight.
  logic                         s1_valid_q;
  logic [COL_AW-1:0]            s1_col_q;
  logic [7:0]                   s1_v_q;
  logic                         s1_has_q;
  logic [hbs_pkg::OROW_W-1:0]   s1_row_q;
  logic [hbs_pkg::OCOL_W-1:0]   s1_ocol_q;
  logic                         s1_last_q;
  logic [2:0]                   s1_rmask_q;
  logic [2:0]                   s1_cmask_q;
  logic [hbs_pkg::CNT_W-1:0]    s1_cnt_q;
  logic                         s1_go;

  // Each entry holds {row r-2, row r-1} of one column.
  logic [15:0] line_mem [MAX_COLUMNS];
  logic [15:0] rd_q;
  logic [15:0] fwd_data_q;
  logic        fwd_q;
  logic [15:0] rd_word;
  logic [15:0] wr_data;

  logic [7:0]               win_q [3][3];
  logic [7:0]               nw    [3][3];
  logic [hbs_pkg::SUM_W-1:0] row_sum [3];
  logic [hbs_pkg::SUM_W-1:0] win_sum;

  hbs_pkg::mean_req_t req;
  logic               req_valid;

  always_comb begin
    if (cols_raw_q == '0) begin
      w_eff = COL_CW'(1);
    end else if (32'(cols_raw_q) > MAX_COLUMNS) begin
      w_eff = COL_CW'(MAX_COLUMNS);
    end else begin
      w_eff = COL_CW'(cols_raw_q);
    end
    if (rows_raw_q == '0) begin
      h_eff = ROW_CW'(1);
    end else if (32'(rows_raw_q) > MAX_ROWS) begin
      h_eff = ROW_CW'(MAX_ROWS);
    end else begin
      h_eff = ROW_CW'(rows_raw_q);
    end
  end

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // A word at column zero finishes the last column of the row two back, using
  // the window before it shifts; any other word finishes the previous column
  // of the row above, using the window after it shifts. In both cases the
  // needed cells sit in the shifted window, so only the column mask differs.
  always_comb begin
    col_ext = COL_CW'(col_q);
    col_inc = col_ext + COL_CW'(1);
    is_a    = (col_q == '0) && (row_q >= ROW_CW'(2));
    is_b    = (col_q != '0) && (row_q != '0) && ((row_q - ROW_CW'(1)) < h_eff);
    has     = is_a || is_b;
    orow    = is_a ? row_q - ROW_CW'(2) : row_q - ROW_CW'(1);
    ocol    = is_a ? w_eff - COL_CW'(1) : col_ext - COL_CW'(1);
    last    = (orow == h_eff - ROW_CW'(1)) && (ocol == w_eff - COL_CW'(1));
    rmask   = {(orow + ROW_CW'(1)) < h_eff, 1'b1, orow != '0};
    cmask   = {!is_a, 1'b1, is_a ? (w_eff >= COL_CW'(2)) : (ocol != '0)};
    nrows   = 2'd1 + 2'(rmask[0]) + 2'(rmask[2]);
    ncols   = 2'd1 + 2'(cmask[0]) + 2'(cmask[2]);
    cnt     = hbs_pkg::CNT_W'(nrows) * hbs_pkg::CNT_W'(ncols);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (has && last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc == w_eff) begin
        col_d = '0;
        if (32'(row_q) < 32'(h_eff) + 32'd2) begin
          row_d = row_q + ROW_CW'(1);
        end
      end else begin
        col_d = COL_AW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_raw_q <= hbs_pkg::COLS_RAW_W'(hbs_pkg::COLS_RESET);
      rows_raw_q <= hbs_pkg::ROWS_RAW_W'(hbs_pkg::ROWS_RESET);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == hbs_pkg::REG_MAP_COLUMNS) begin
        cols_raw_q <= cfg_data_i[hbs_pkg::COLS_RAW_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == hbs_pkg::REG_MAP_ROWS) begin
        rows_raw_q <= cfg_data_i[hbs_pkg::ROWS_RAW_W-1:0];
      end
      col_q <= col_d;
      row_q <= row_d;
      if (adv) begin
        s1_valid_q <= accept;
      end
      // A one-column map, or the first word after a frame-last word, reads
      // the entry that the word ahead is writing.
      if (accept) begin
        fwd_q <= s1_go && (s1_col_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= col_q;
      s1_v_q     <= (in_word_i.opcode == hbs_pkg::OP_FLUSH) ? 8'd0 : in_word_i.sample_byte;
      s1_has_q   <= has;
      s1_row_q   <= hbs_pkg::OROW_W'(orow);
      s1_ocol_q  <= hbs_pkg::OCOL_W'(ocol);
      s1_last_q  <= last;
      s1_rmask_q <= rmask;
      s1_cmask_q <= cmask;
      s1_cnt_q   <= cnt;
      fwd_data_q <= wr_data;
    end
  end

  assign s1_go   = s1_valid_q && adv;
  assign rd_word = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {rd_word[7:0], s1_v_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_go) begin
      line_mem[s1_col_q] <= wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nw[k][0] = win_q[k][1];
      nw[k][1] = win_q[k][2];
    end
    nw[0][2] = rd_word[15:8];
    nw[1][2] = rd_word[7:0];
    nw[2][2] = s1_v_q;
    for (int k = 0; k < 3; k++) begin
      row_sum[k] = '0;
      if (s1_rmask_q[k]) begin
        row_sum[k] = (s1_cmask_q[0] ? hbs_pkg::SUM_W'(nw[k][0]) : '0)
                   + (s1_cmask_q[1] ? hbs_pkg::SUM_W'(nw[k][1]) : '0)
                   + (s1_cmask_q[2] ? hbs_pkg::SUM_W'(nw[k][2]) : '0);
      end
    end
    win_sum = row_sum[0] + row_sum[1] + row_sum[2];
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= nw[k][j];
        end
      end
    end
  end

  always_comb begin
    req.sum   = win_sum;
    req.cnt   = s1_cnt_q;
    req.row   = s1_row_q;
    req.col   = s1_ocol_q;
    req.last  = s1_last_q;
    req_valid = s1_valid_q && s1_has_q;
  end

  hbs_mean_div u_mean_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_valid_i (req_valid),
    .req_i       (req),
    .res_valid_o (out_valid_o),
    .res_o       (out_word_o)
  );

endmodule

FILE: sv/hbs_checker.sv
module hbs_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  hbs_pkg::out_word_t out_word_o
);

  // Set while the next word to leave must be the first position of a frame.
  logic frame_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= 1'b1;
    end else if (cfg_we_i) begin
      frame_start_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      frame_start_q <= out_word_o.frame_last;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.smoothed_height <= 16'd38400)
    else $error("smoothed height out of range");

  a_frame_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_start_q |-> out_word_o.out_row == '0 && out_word_o.out_col == '0)
    else $error("frame did not start at the map origin");

endmodule

bind heightmap_box_smooth_3x3_core hbs_checker u_hbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

FILE: test/tb_heightmap_box_smooth_3x3_core.sv
`timescale 1ns / 1ps

module tb_heightmap_box_smooth_3x3_core;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_WORDS = 520;
  localparam int CLAMP_WORDS = 32;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [hbs_pkg::CFG_AW-1:0]    cfg_idx = '0;
  logic [hbs_pkg::CFG_DW-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  hbs_pkg::in_word_t             in_word = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  hbs_pkg::out_word_t            out_word;

  heightmap_box_smooth_3x3_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #1 clk = ~clk;

  // Words waiting to be driven and smoothed results waiting to arrive.
  hbs_pkg::in_word_t  sample_queue[$];
  hbs_pkg::out_word_t expected_heights[$];
  int        words_queued = 0;
  int        words_accepted = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  // Shadow copy of the smoothing state.
  int unsigned cols_raw;
  int unsigned rows_raw;
  logic [7:0]  upper_line[1024];
  logic [7:0]  middle_line[1024];
  logic [7:0]  nbhd[3][3];
  int          cur_row;
  int          cur_col;

  function automatic int map_w();
    if (cols_raw < 1) return 1;
    if (cols_raw > hbs_pkg::MAX_COLUMNS_DEF) return hbs_pkg::MAX_COLUMNS_DEF;
    return cols_raw;
  endfunction

  function automatic int map_h();
    if (rows_raw < 1) return 1;
    if (rows_raw > hbs_pkg::MAX_ROWS_DEF) return hbs_pkg::MAX_ROWS_DEF;
    return rows_raw;
  endfunction

  // Mean of the in-map cells around (orow, ocol); the center is nbhd[1][ccol].
  function automatic int box_mean(int ccol, int orow, int ocol, int w, int h);
    int sum, n, rr, cc, wc;
    sum = 0;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      rr = orow + dr;
      if (rr >= 0 && rr < h) begin
        for (int dc = -1; dc <= 1; dc++) begin
          cc = ocol + dc;
          wc = ccol + dc;
          if (cc >= 0 && cc < w && wc >= 0 && wc <= 2) begin
            sum += nbhd[1 + dr][wc];
            n++;
          end
        end
      end
    end
    return (n == 0) ? 0 : (sum * 38400) / (255 * n);
  endfunction

  // Returns 0 when the position lies outside the map, 2 on the frame's last one.
  function automatic int push_position(int ccol, int orow, int ocol, int w, int h);
    hbs_pkg::out_word_t o;
    logic      last;
    if (orow >= h || ocol >= w) return 0;
    last = (orow == h - 1) && (ocol == w - 1);
    o.smoothed_height = hbs_pkg::HEIGHT_W'(box_mean(ccol, orow, ocol, w, h));
    o.out_row = hbs_pkg::OROW_W'(orow);
    o.out_col = hbs_pkg::OCOL_W'(ocol);
    o.frame_last = last;
    expected_heights.push_back(o);
    return last ? 2 : 1;
  endfunction

  task automatic predict_box_mean(input hbs_pkg::in_word_t wd);
    int         w, h, c, r, res;
    logic [7:0] v, a, b;
    w = map_w();
    h = map_h();
    c = cur_col;
    r = cur_row;
    v = (wd.opcode == hbs_pkg::OP_FLUSH) ? 8'd0 : wd.sample_byte;
    res = 0;
    if (c >= w) c = 0;
    // The first word of a row completes the last column of the row two above.
    if (c == 0 && r >= 2) res = push_position(2, r - 2, w - 1, w, h);
    a = upper_line[c];
    b = middle_line[c];
    for (int k = 0; k < 3; k++) begin
      nbhd[k][0] = nbhd[k][1];
      nbhd[k][1] = nbhd[k][2];
    end
    nbhd[0][2] = a;
    nbhd[1][2] = b;
    nbhd[2][2] = v;
    upper_line[c] = b;
    middle_line[c] = v;
    if (res == 0 && c >= 1 && r >= 1) res = push_position(1, r - 1, c - 1, w, h);
    if (res == 2) begin
      cur_row = 0;
      cur_col = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        if (r < h + 2) r++;
      end
      cur_col = c;
      cur_row = r;
    end
  endtask

  // Register write through the port; it also restarts the shadow frame.
  task automatic write_size(input logic [hbs_pkg::CFG_AW-1:0] idx,
                            input logic [hbs_pkg::CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hbs_pkg::REG_MAP_COLUMNS) cols_raw = 32'(data & 13'h7FF);
    else rows_raw = 32'(data);
    cur_row = 0;
    cur_col = 0;
  endtask

  function automatic logic [7:0] pick_height();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic queue_word(input logic op, input logic [7:0] b);
    hbs_pkg::in_word_t wd;
    wd.opcode = op;
    wd.sample_byte = b;
    sample_queue.push_back(wd);
    words_queued++;
  endtask

  // A whole frame with the occasional flush in place of a sample, then the drain.
  task automatic queue_frame();
    int w, h;
    w = map_w();
    h = map_h();
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(19) == 0) queue_word(hbs_pkg::OP_FLUSH, 8'($urandom()));
      else queue_word(hbs_pkg::OP_SAMPLE, pick_height());
    end
    for (int i = 0; i <= w; i++) queue_word(hbs_pkg::OP_FLUSH, 8'($urandom()));
  endtask

  task automatic queue_broken();
    int cnt;
    cnt = $urandom_range(map_w() * map_h() + map_w(), 1);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(3) == 0) queue_word(hbs_pkg::OP_FLUSH, 8'($urandom()));
      else queue_word(hbs_pkg::OP_SAMPLE, pick_height());
    end
  endtask

  // Wait until every queued word is accepted and every result has arrived.
  task automatic drain();
    while (words_accepted != words_queued || expected_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase(input int p);
    case (p)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 69; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 69; end
      default: begin send_idle_pct = 34; stall_pct = 34; end
    endcase
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_box_mean(in_word);
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= sample_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  hbs_pkg::out_word_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_heights.size() == 0) begin
        $error("unexpected result word: row %0d col %0d", out_word.out_row, out_word.out_col);
        mismatch_count++;
      end else begin
        want = expected_heights.pop_front();
        if (out_word.smoothed_height !== want.smoothed_height) begin
          $error("smoothed_height: expected %0d, got %0d",
                 want.smoothed_height, out_word.smoothed_height);
          mismatch_count++;
        end
        if (out_word.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_word.out_row);
          mismatch_count++;
        end
        if (out_word.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_word.out_col);
          mismatch_count++;
        end
        if (out_word.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, out_word.frame_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int chunk, pick, nframes, first_random;
    cols_raw = hbs_pkg::COLS_RESET;
    rows_raw = hbs_pkg::ROWS_RESET;
    for (int i = 0; i < 1024; i++) begin
      upper_line[i] = 8'h00;
      middle_line[i] = 8'h00;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) nbhd[i][j] = 8'h00;
    cur_row = 0;
    cur_col = 0;
    set_phase(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 map: corners, edges and the center, with both extreme heights.
    write_size(hbs_pkg::REG_MAP_COLUMNS, 13'd3);
    write_size(hbs_pkg::REG_MAP_ROWS, 13'd3);
    queue_word(hbs_pkg::OP_SAMPLE, 8'h00);
    queue_word(hbs_pkg::OP_SAMPLE, 8'hFF);
    queue_word(hbs_pkg::OP_SAMPLE, 8'hFF);
    queue_word(hbs_pkg::OP_SAMPLE, 8'hFF);
    queue_word(hbs_pkg::OP_SAMPLE, 8'h80);
    queue_word(hbs_pkg::OP_SAMPLE, 8'h01);
    queue_word(hbs_pkg::OP_SAMPLE, 8'h00);
    queue_word(hbs_pkg::OP_SAMPLE, 8'h00);
    queue_word(hbs_pkg::OP_SAMPLE, 8'hFF);
    for (int i = 0; i < 4; i++) queue_word(hbs_pkg::OP_FLUSH, 8'hFF);
    drain();

    // Zero sizes count as a single cell.
    write_size(hbs_pkg::REG_MAP_COLUMNS, 13'd0);
    write_size(hbs_pkg::REG_MAP_ROWS, 13'd0);
    queue_word(hbs_pkg::OP_SAMPLE, 8'hFF);
    queue_word(hbs_pkg::OP_FLUSH, 8'hAA);
    queue_word(hbs_pkg::OP_FLUSH, 8'h55);
    drain();

    // A flush inside the frame stands for a zero sample.
    write_size(hbs_pkg::REG_MAP_COLUMNS, 13'd2);
    write_size(hbs_pkg::REG_MAP_ROWS, 13'd2);
    queue_word(hbs_pkg::OP_SAMPLE, 8'd200);
    queue_word(hbs_pkg::OP_FLUSH, 8'hFF);
    queue_word(hbs_pkg::OP_SAMPLE, 8'd77);
    queue_word(hbs_pkg::OP_SAMPLE, 8'hFF);
    for (int i = 0; i < 3; i++) queue_word(hbs_pkg::OP_FLUSH, 8'h00);
    drain();

    chunk = 0;
    first_random = words_queued;
    while (words_queued - first_random < RANDOM_WORDS) begin
      set_phase(chunk % 4);
      pick = $urandom_range(2);
      if (pick != 1)
        write_size(hbs_pkg::REG_MAP_COLUMNS,
                   13'($urandom_range(8)) | (13'($urandom_range(3)) << 11));
      if (pick != 0) write_size(hbs_pkg::REG_MAP_ROWS, 13'($urandom_range(8)));
      nframes = $urandom_range(3, 1);
      for (int f = 0; f < nframes; f++) begin
        if (f == nframes - 1 && $urandom_range(3) == 0) queue_broken();
        else queue_frame();
      end
      drain();
      chunk++;
    end

    // The start of the widest map and of the tallest map, both reached
    // through clamping.
    set_phase(3);
    write_size(hbs_pkg::REG_MAP_COLUMNS, 13'd2047);
    write_size(hbs_pkg::REG_MAP_ROWS, 13'd0);
    for (int i = 0; i < CLAMP_WORDS; i++) queue_word(hbs_pkg::OP_SAMPLE, pick_height());
    drain();
    write_size(hbs_pkg::REG_MAP_COLUMNS, 13'd0);
    write_size(hbs_pkg::REG_MAP_ROWS, 13'd8191);
    for (int i = 0; i < CLAMP_WORDS; i++) queue_word(hbs_pkg::OP_SAMPLE, pick_height());
    drain();

    if (mismatch_count == 0 && expected_heights.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
